// ===== hdl/rtm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtm_pkg: shared codes for the radix trie map
// Operation and status codes used by the control engine and the top level.
// ----------------------------------------------------------------------------
package rtm_pkg;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_FLOOR  = 3'd3;
    localparam logic [2:0] OP_NEXT   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

// ===== hdl/rtm_engine.sv =====
// ----------------------------------------------------------------------------
// rtm_engine: trie walk sequencer
// Holds the slot memory, the node free stack and the valid-bit table, and
// runs one operation at a time, one slot access after another.
// ----------------------------------------------------------------------------
module rtm_engine
    import rtm_pkg::*;
#(
    parameter int KEY_BITS   = 16,
    parameter int LEVEL_BITS = 4,
    parameter int NODE_POOL  = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2:0]            op,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  idle,
    output logic                  done,
    output logic [1:0]            res_status,
    output logic [KEY_BITS-1:0]   res_key,
    output logic [VALUE_BITS-1:0] res_value
);

    localparam int LEVELS  = KEY_BITS / LEVEL_BITS;
    localparam int FANOUT  = 1 << LEVEL_BITS;
    localparam int NB      = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
    localparam int SB      = NB + LEVEL_BITS;
    localparam int NSLOTS  = NODE_POOL * FANOUT;
    localparam int LB      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CB      = $clog2(NODE_POOL + 1);
    localparam int DW      = (VALUE_BITS > NB) ? VALUE_BITS : NB;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_CLEAR   = 11'b00000000010,
        S_WALK    = 11'b00000000100,
        S_WALKRD  = 11'b00000001000,
        S_INS     = 11'b00000010000,
        S_UNDO    = 11'b00000100000,
        S_RMCHK   = 11'b00001000000,
        S_RMRD    = 11'b00010000000,
        S_FL      = 11'b00100000000,
        S_FLRD    = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    // Slot memory holds data; a separate bit memory holds each slot's
    // valid flag so whole nodes can be scanned slot by slot.
    logic [DW-1:0]   data_mem [NSLOTS];
    logic            ok_mem   [NSLOTS];
    logic [NB-1:0]   free_mem [NODE_POOL];

    state_t                state_reg;
    logic [SB-1:0]         clr_reg;
    logic [2:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [LB-1:0]         lvl_reg;
    logic [LEVEL_BITS:0]   d_reg;
    logic [NB-1:0]         node_reg [LEVELS];
    logic [LEVEL_BITS-1:0] dig_reg  [LEVELS];
    logic                  tight_reg[LEVELS];
    logic [NB-1:0]         newn_reg [LEVELS];
    logic [LB:0]           cnt_reg;
    logic [CB-1:0]         fcnt_reg;
    logic [KEY_BITS-1:0]   ckey_reg;
    logic                  cvalid_reg;
    logic [1:0]            st_reg;
    logic [KEY_BITS-1:0]   fk_reg;
    logic [VALUE_BITS-1:0] fv_reg;

    logic [DW-1:0] rd_data;
    logic          rd_ok;
    logic [NB-1:0] free_rd;

    logic          ok_we, ok_wd, data_we;
    logic [SB-1:0] ok_wa, data_wa, rd_a;
    logic [DW-1:0] data_wd;
    logic          free_we;
    logic [NB-1:0] free_wa, free_wd, free_ra;

    function automatic logic [LEVEL_BITS-1:0] dig_of(input logic [KEY_BITS-1:0] k,
                                                     input logic [LB-1:0] l);
        logic [KEY_BITS-1:0] s;
        s = k >> ((LEVELS - 1 - int'(l)) * LEVEL_BITS);
        return s[LEVEL_BITS-1:0];
    endfunction

    function automatic logic [SB-1:0] sidx(input logic [NB-1:0] n,
                                           input logic [LEVEL_BITS-1:0] d);
        return {n, d};
    endfunction

    always_ff @(posedge aclk) begin
        if (ok_we) ok_mem[ok_wa] <= ok_wd;
        if (data_we) data_mem[data_wa] <= data_wd;
        if (free_we) free_mem[free_wa] <= free_wd;
        rd_ok   <= ok_mem[rd_a];
        rd_data <= data_mem[rd_a];
        free_rd <= free_mem[free_ra];
    end

    logic [LEVEL_BITS-1:0] cur_dig;
    logic [NB-1:0]         cur_node;
    logic                  last_lvl;
    logic [LEVEL_BITS-1:0] d_low;
    logic [KEY_BITS-1:0]   fl_key;
    logic [KEY_BITS-1:0]   asm_key;

    always_comb begin
        cur_node = node_reg[lvl_reg];
        cur_dig  = dig_of(key_reg, lvl_reg);
        last_lvl = (int'(lvl_reg) == LEVELS - 1);
        d_low    = d_reg[LEVEL_BITS-1:0];
        fl_key   = key_reg;
        asm_key  = '0;
        for (int i = 0; i < LEVELS; i++) begin
            asm_key = (asm_key << LEVEL_BITS) | KEY_BITS'(dig_reg[i]);
        end
        asm_key[LEVEL_BITS-1:0] = d_low;
    end

    // Control state machine.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            fcnt_reg   <= CB'(NODE_POOL - 1);
            cvalid_reg <= 1'b0;
            ckey_reg   <= '0;
            cnt_reg    <= '0;
            lvl_reg    <= '0;
            d_reg      <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SB'(NSLOTS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        op_reg      <= op;
                        val_reg     <= value;
                        lvl_reg     <= '0;
                        cnt_reg     <= '0;
                        node_reg[0] <= '0;
                        tight_reg[0] <= 1'b1;
                        st_reg      <= ST_MISS;
                        fk_reg      <= '0;
                        fv_reg      <= '0;
                        priority case (1'b1)
                            op == OP_LOOKUP || op == OP_REMOVE || op == OP_INSERT: begin
                                key_reg   <= key;
                                state_reg <= S_WALK;
                            end
                            op == OP_FLOOR: begin
                                key_reg   <= key;
                                d_reg     <= {1'b0, dig_of(key, '0)};
                                state_reg <= S_FL;
                            end
                            op == OP_NEXT && cvalid_reg && ckey_reg != '0: begin
                                key_reg   <= ckey_reg - 1'b1;
                                d_reg     <= {1'b0, dig_of(ckey_reg - 1'b1, '0)};
                                state_reg <= S_FL;
                            end
                            default: begin
                                if (op == OP_NEXT) cvalid_reg <= 1'b0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WALK: state_reg <= S_WALKRD;
                S_WALKRD: begin
                    if (op_reg == OP_INSERT) begin
                        if (last_lvl) begin
                            st_reg    <= ST_OK;
                            state_reg <= S_DONE;
                        end else if (rd_ok) begin
                            node_reg[lvl_reg + 1'b1] <= rd_data[NB-1:0];
                            lvl_reg   <= lvl_reg + 1'b1;
                            state_reg <= S_WALK;
                        end else if (fcnt_reg == '0) begin
                            state_reg <= S_UNDO;
                        end else begin
                            fcnt_reg  <= fcnt_reg - 1'b1;
                            d_reg     <= '0;
                            state_reg <= S_INS;
                        end
                    end else if (!rd_ok) begin
                        state_reg <= S_DONE;
                    end else if (last_lvl) begin
                        st_reg <= ST_OK;
                        fv_reg <= rd_data[VALUE_BITS-1:0];
                        if (op_reg == OP_REMOVE && LEVELS > 1) begin
                            d_reg     <= '0;
                            state_reg <= S_RMCHK;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else begin
                        node_reg[lvl_reg + 1'b1] <= rd_data[NB-1:0];
                        lvl_reg   <= lvl_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                // New node popped (free_rd valid); clear its slots, then link.
                S_INS: begin
                    d_reg <= d_reg + 1'b1;
                    if (d_reg == (LEVEL_BITS+1)'(FANOUT)) begin
                        newn_reg[cnt_reg[LB-1:0]] <= free_rd;
                        cnt_reg  <= cnt_reg + 1'b1;
                        node_reg[lvl_reg + 1'b1] <= free_rd;
                        lvl_reg   <= lvl_reg + 1'b1;
                        state_reg <= S_WALK;
                    end
                end
                // Pool full: unlink and push back nodes this insert took.
                S_UNDO: begin
                    if (cnt_reg == '0) begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_DONE;
                    end else begin
                        cnt_reg  <= cnt_reg - 1'b1;
                        lvl_reg  <= lvl_reg - 1'b1;
                        fcnt_reg <= fcnt_reg + 1'b1;
                    end
                end
                // Scan node at lvl for live slots after a removal.
                S_RMCHK: begin
                    state_reg <= S_RMRD;
                end
                S_RMRD: begin
                    if (rd_ok) begin
                        state_reg <= S_DONE;
                    end else if (d_reg == (LEVEL_BITS+1)'(FANOUT - 1)) begin
                        fcnt_reg <= fcnt_reg + 1'b1;
                        if (lvl_reg == LB'(1)) begin
                            state_reg <= S_DONE;
                        end else begin
                            lvl_reg   <= lvl_reg - 1'b1;
                            d_reg     <= '0;
                            state_reg <= S_RMCHK;
                        end
                    end else begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= S_RMCHK;
                    end
                end
                S_FL: begin
                    if (d_reg[LEVEL_BITS]) begin
                        if (lvl_reg == '0) begin
                            cvalid_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end else begin
                            lvl_reg <= lvl_reg - 1'b1;
                            d_reg   <= {1'b0, dig_reg[lvl_reg - 1'b1]} - 1'b1;
                        end
                    end else begin
                        state_reg <= S_FLRD;
                    end
                end
                S_FLRD: begin
                    if (!rd_ok) begin
                        d_reg     <= d_reg - 1'b1;
                        state_reg <= S_FL;
                    end else begin
                        dig_reg[lvl_reg] <= d_low;
                        if (last_lvl) begin
                            st_reg     <= ST_OK;
                            fk_reg     <= asm_key;
                            fv_reg     <= rd_data[VALUE_BITS-1:0];
                            ckey_reg   <= asm_key;
                            cvalid_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end else begin
                            node_reg[lvl_reg + 1'b1]  <= rd_data[NB-1:0];
                            tight_reg[lvl_reg + 1'b1] <= tight_reg[lvl_reg] &&
                                                         d_low == cur_dig;
                            lvl_reg <= lvl_reg + 1'b1;
                            d_reg   <= (tight_reg[lvl_reg] && d_low == cur_dig) ?
                                       {1'b0, dig_of(fl_key, lvl_reg + 1'b1)} :
                                       (LEVEL_BITS+1)'(FANOUT - 1);
                            state_reg <= S_FL;
                        end
                    end
                end
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    // Memory port drive, decided from the current state.
    always_comb begin
        ok_we   = 1'b0;
        ok_wa   = sidx(cur_node, cur_dig);
        ok_wd   = 1'b0;
        data_we = 1'b0;
        data_wa = sidx(cur_node, cur_dig);
        data_wd = '0;
        rd_a    = sidx(cur_node, cur_dig);
        free_we = 1'b0;
        free_wa = fcnt_reg[NB-1:0];
        free_wd = '0;
        free_ra = NB'(fcnt_reg - 1'b1);
        unique case (state_reg)
            S_CLEAR: begin
                ok_we = 1'b1;
                ok_wa = clr_reg;
                free_we = clr_reg < SB'(NODE_POOL);
                free_wa = clr_reg[NB-1:0];
                free_wd = NB'(clr_reg + 1'b1);
            end
            S_WALKRD: begin
                if (op_reg == OP_INSERT && last_lvl) begin
                    ok_we = 1'b1; ok_wd = 1'b1;
                    data_we = 1'b1;
                    data_wd = DW'(val_reg);
                end else if (op_reg == OP_REMOVE && last_lvl && rd_ok) begin
                    // Removal clears the value slot before its node is scanned.
                    ok_we = 1'b1;
                end
            end
            S_INS: begin
                // The popped entry sits at the decremented count; keep reading it.
                free_ra = fcnt_reg[NB-1:0];
                if (d_reg == (LEVEL_BITS+1)'(FANOUT)) begin
                    ok_we = 1'b1; ok_wd = 1'b1;
                    data_we = 1'b1;
                    data_wd = DW'(free_rd);
                end else begin
                    ok_we = 1'b1;
                    ok_wa = sidx(free_rd, d_low);
                end
            end
            S_UNDO: begin
                if (cnt_reg != '0) begin
                    ok_we = 1'b1;
                    ok_wa = sidx(node_reg[lvl_reg - 1'b1],
                                 dig_of(key_reg, lvl_reg - 1'b1));
                    free_we = 1'b1;
                    free_wd = newn_reg[cnt_reg[LB-1:0] - 1'b1];
                end
            end
            S_RMCHK: begin
                rd_a = sidx(cur_node, d_low);
            end
            S_RMRD: begin
                if (!rd_ok && d_reg == (LEVEL_BITS+1)'(FANOUT - 1)) begin
                    ok_we = 1'b1;
                    ok_wa = sidx(node_reg[lvl_reg - 1'b1],
                                 dig_of(key_reg, lvl_reg - 1'b1));
                    free_we = 1'b1;
                    free_wd = cur_node;
                end
            end
            S_FL: rd_a = sidx(cur_node, d_low);
            default: ;
        endcase
    end

    assign idle       = (state_reg == S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign res_status = st_reg;
    assign res_key    = fk_reg;
    assign res_value  = fv_reg;

endmodule

// ===== hdl/radix_trie_map.sv =====
// ----------------------------------------------------------------------------
// radix_trie_map: sparse key/value map on a fixed-depth radix trie
// Lookup, insert, remove, floor search and step to the next lower key.
// ----------------------------------------------------------------------------
// Input words (s_op, s_key, s_value) are taken on s_valid and s_ready; each
// gives exactly one result word (m_status, m_found_key, m_found_value).
// One word is processed at a time; the slot memory has a registered read, so
// each level of a lookup or insert issues a read and then acts on its data;
// insert also clears every slot of each node it takes from the pool, remove
// scans up to FANOUT slots per freed node, and a floor search or step scans
// up to FANOUT slots per level, with backtracking. The result word is loaded
// into the output register from the engine's done state.
// After reset a clearing pass writes every slot; s_ready is low during it. A
// result waits in the output register while the receiver stalls; the next
// word is accepted once that register is free or being emptied.
// ----------------------------------------------------------------------------
module radix_trie_map
    import rtm_pkg::*;
#(
    parameter int KEY_BITS   = 16,
    parameter int LEVEL_BITS = 4,
    parameter int NODE_POOL  = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_op,
    input  logic [KEY_BITS-1:0]   s_key,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [KEY_BITS-1:0]   m_found_key,
    output logic [VALUE_BITS-1:0] m_found_value
);

    logic                  eng_idle;
    logic                  done;
    logic [1:0]            res_status;
    logic [KEY_BITS-1:0]   res_key;
    logic [VALUE_BITS-1:0] res_value;
    logic                  start;

    // Ready only while the engine is idle and the output register is free or being emptied.
    assign s_ready = eng_idle && (!m_valid || m_ready);
    assign start   = s_valid && s_ready;

    rtm_engine #(
        .KEY_BITS(KEY_BITS), .LEVEL_BITS(LEVEL_BITS),
        .NODE_POOL(NODE_POOL), .VALUE_BITS(VALUE_BITS)
    ) u_engine (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .op(s_op), .key(s_key), .value(s_value),
        .idle(eng_idle), .done(done), .res_status(res_status),
        .res_key(res_key), .res_value(res_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else begin
            if (done) begin
                m_valid       <= 1'b1;
                m_status      <= res_status;
                m_found_key   <= res_key;
                m_found_value <= res_value;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !m_valid) else $error("result while output register full");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_ready) else $error("second word accepted while busy");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3) else $error("bad status code");

endmodule

// ===== tb/radix_trie_map_checker.sv =====
// ----------------------------------------------------------------------------
// radix_trie_map_checker: prediction and comparison for the radix trie map
// Watches both channels, keeps its own copy of the trie, the node pool and
// the search cursor, and compares every result word with the oldest expected
// one. Mismatches and left-over expectations are counted for the top level.
// ----------------------------------------------------------------------------
module radix_trie_map_checker
    import rtm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [15:0] s_key,
    input  logic [31:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_found_key,
    input  logic [31:0] m_found_value,
    output int          fail_count,
    output int          pending,
    output int          full_count,
    output int          hit_count
);

    localparam int FANOUT = 16;
    localparam int LEVELS = 4;
    localparam int POOL   = 256;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fkey;
        logic [31:0] fval;
    } map_result_t;

    bit          slot_ok   [POOL*FANOUT];
    logic [31:0] slot_data [POOL*FANOUT];
    int          free_stack[POOL];
    int          free_cnt;
    logic [15:0] cur_key;
    int          cur_path[LEVELS];
    bit          cur_valid;

    map_result_t expected_results[$];

    function automatic int slot_index(int node, int d);
        return (node % POOL) * FANOUT + (d & (FANOUT - 1));
    endfunction

    function automatic int key_digit(logic [15:0] key, int lvl);
        return int'((key >> ((LEVELS - 1 - lvl) * 4)) & 16'hF);
    endfunction

    function automatic bit node_is_empty(int node);
        for (int d = 0; d < FANOUT; d++)
            if (slot_ok[slot_index(node, d)]) return 0;
        return 1;
    endfunction

    function automatic void free_node(int node);
        for (int d = 0; d < FANOUT; d++) slot_ok[slot_index(node, d)] = 0;
        if (free_cnt < POOL) begin
            free_stack[free_cnt] = node;
            free_cnt++;
        end
    endfunction

    // Largest key at or below the given one, backing out of dead ends.
    function automatic bit find_floor(logic [15:0] key, output logic [15:0] fk,
                                      output logic [31:0] fv);
        int node[LEVELS];
        int dig[LEVELS];
        bit tight[LEVELS];
        int lvl;
        int d;
        logic [15:0] k;
        lvl = 0;
        d = key_digit(key, 0);
        node[0] = 0;
        tight[0] = 1;
        fk = '0;
        fv = '0;
        forever begin
            while (d >= 0 && !slot_ok[slot_index(node[lvl], d)]) d--;
            if (d < 0) begin
                if (lvl == 0) return 0;
                lvl--;
                d = dig[lvl] - 1;
                continue;
            end
            dig[lvl] = d;
            if (lvl == LEVELS - 1) break;
            node[lvl+1] = int'(slot_data[slot_index(node[lvl], d)] % POOL);
            tight[lvl+1] = tight[lvl] && (dig[lvl] == key_digit(key, lvl));
            lvl++;
            d = tight[lvl] ? key_digit(key, lvl) : FANOUT - 1;
        end
        k = '0;
        for (int i = 0; i < LEVELS; i++) k = (k << 4) | 16'(dig[i]);
        fk = k;
        fv = slot_data[slot_index(node[LEVELS-1], dig[LEVELS-1])];
        for (int i = 0; i < LEVELS; i++) cur_path[i] = 0;
        for (int i = 1; i < LEVELS; i++) cur_path[i-1] = node[i];
        cur_key = k;
        cur_valid = 1;
        return 1;
    endfunction

    function automatic void clear_map();
        for (int i = 0; i < POOL * FANOUT; i++) begin
            slot_ok[i] = 0;
            slot_data[i] = '0;
        end
        for (int i = 0; i + 1 < POOL; i++) free_stack[i] = i + 1;
        free_stack[POOL-1] = 0;
        free_cnt = POOL - 1;
        cur_key = '0;
        for (int i = 0; i < LEVELS; i++) cur_path[i] = 0;
        cur_valid = 0;
    endfunction

    function automatic map_result_t predict_map_op(logic [2:0] op, logic [15:0] key,
                                                   logic [31:0] value);
        map_result_t r;
        int path[LEVELS];
        int newn[LEVELS];
        int news[LEVELS];
        int node;
        int s;
        int n;
        int cnt;
        bit hit;
        bit full;
        bit ok;
        logic [15:0] fk;
        logic [31:0] fv;
        r = '{status: ST_MISS, fkey: '0, fval: '0};
        node = 0;
        if (op == OP_LOOKUP || op == OP_REMOVE) begin
            hit = 1;
            for (int lvl = 0; lvl < LEVELS; lvl++) begin
                path[lvl] = node;
                s = slot_index(node, key_digit(key, lvl));
                if (!slot_ok[s]) begin
                    hit = 0;
                    break;
                end
                if (lvl == LEVELS - 1) r.fval = slot_data[s];
                else node = int'(slot_data[s] % POOL);
            end
            if (hit) begin
                r.status = ST_OK;
                if (op == OP_REMOVE) begin
                    slot_ok[slot_index(path[LEVELS-1], key_digit(key, LEVELS-1))] = 0;
                    for (int lvl = LEVELS - 1; lvl >= 1; lvl--) begin
                        if (!node_is_empty(path[lvl])) break;
                        free_node(path[lvl]);
                        slot_ok[slot_index(path[lvl-1], key_digit(key, lvl-1))] = 0;
                    end
                end
            end else begin
                r.fval = '0;
            end
        end else if (op == OP_INSERT) begin
            cnt = 0;
            full = 0;
            for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
                s = slot_index(node, key_digit(key, lvl));
                if (!slot_ok[s]) begin
                    if (free_cnt == 0) begin
                        full = 1;
                        break;
                    end
                    free_cnt--;
                    n = free_stack[free_cnt] % POOL;
                    for (int d = 0; d < FANOUT; d++) slot_ok[slot_index(n, d)] = 0;
                    slot_ok[s] = 1;
                    slot_data[s] = 32'(n);
                    newn[cnt] = n;
                    news[cnt] = s;
                    cnt++;
                end
                node = int'(slot_data[s] % POOL);
            end
            if (full) begin
                // Give back whatever this insert took from the pool.
                while (cnt > 0) begin
                    cnt--;
                    slot_ok[news[cnt]] = 0;
                    free_node(newn[cnt]);
                end
                r.status = ST_FULL;
            end else begin
                s = slot_index(node, key_digit(key, LEVELS - 1));
                slot_ok[s] = 1;
                slot_data[s] = value;
                r.status = ST_OK;
            end
        end else if (op == OP_FLOOR || op == OP_NEXT) begin
            ok = 0;
            if (op == OP_FLOOR) ok = find_floor(key, fk, fv);
            else if (cur_valid && cur_key != 0) ok = find_floor(cur_key - 16'd1, fk, fv);
            if (ok) begin
                r.status = ST_OK;
                r.fkey = fk;
                r.fval = fv;
            end else begin
                cur_valid = 0;
            end
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        map_result_t exp_r;
        map_result_t got;
        if (!aresetn) begin
            clear_map();
            expected_results.delete();
            fail_count <= 0;
            full_count <= 0;
            hit_count  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                exp_r = predict_map_op(s_op, s_key, s_value);
                expected_results.push_back(exp_r);
                if (exp_r.status == ST_FULL) full_count <= full_count + 1;
                if (exp_r.status == ST_OK) hit_count <= hit_count + 1;
            end
            if (m_valid && m_ready) begin
                got = '{status: m_status, fkey: m_found_key, fval: m_found_value};
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result word: status %0d key %h value %h",
                                 got.status, got.fkey, got.fval);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                                     exp_r.status, exp_r.fkey, exp_r.fval,
                                     got.status, got.fkey, got.fval);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/radix_trie_map_tb.sv =====
// ----------------------------------------------------------------------------
// radix_trie_map_tb: regression for the radix trie map
// Directed words cover empty-map searches, extreme keys, replace, backtracking
// floor search and the end of iteration; random phases mix all operations on
// small key sets, fill the node pool until inserts are refused, then drain it.
// ----------------------------------------------------------------------------
module radix_trie_map_tb;
    import rtm_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_op;
    logic [15:0] s_key;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_found_key;
    logic [31:0] m_found_value;

    int fail_count;
    int pending;
    int full_count;
    int hit_count;
    int words_sent;
    int idle_cycles = 0;
    int hold_count = 0;
    logic [15:0] key_set[32];

    radix_trie_map i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_key, .s_value,
        .m_valid, .m_ready, .m_status, .m_found_key, .m_found_value
    );

    radix_trie_map_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_key, .s_value,
        .m_valid, .m_ready, .m_status, .m_found_key, .m_found_value,
        .fail_count, .pending, .full_count, .hit_count
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // Offer one word and hold it until it is taken, then idle for a while.
    task automatic send_word(logic [2:0] op, logic [15:0] key, logic [31:0] value,
                             int gap);
        s_valid <= 1'b1;
        s_op    <= op;
        s_key   <= key;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_phase(int count, int insert_weight, int remove_weight,
                                int spread);
        int r;
        logic [2:0] op;
        logic [15:0] key;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < insert_weight) op = OP_INSERT;
            else if (r < insert_weight + remove_weight) op = OP_REMOVE;
            else if (r < 97) op = 3'($urandom_range(OP_NEXT, OP_LOOKUP));
            else op = 3'($urandom_range(7, 5));
            if ($urandom_range(99) < spread) key = 16'($urandom);
            else key = key_set[$urandom_range(31)];
            if (i == count / 2 && insert_weight < 50) hold_count++;
            send_word(op, key, $urandom, ($urandom_range(3) == 0) ? 0 : pick_gap());
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on each request.
    initial begin
        int holds_done;
        holds_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_count != holds_done) begin
                holds_done = hold_count;
                m_ready <= 1'b0;
                repeat (500) @(posedge aclk);
            end
            if ($urandom_range(9) < 7) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("radix_trie_map regression: fail");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_LOOKUP;
        s_key        = '0;
        s_value      = '0;
        words_sent   = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty map, extreme keys and values, replace, and stepping past the end.
        send_word(OP_LOOKUP, 16'h0000, 32'h0, 0);
        send_word(OP_FLOOR,  16'hFFFF, 32'h0, 0);
        send_word(OP_NEXT,   16'h0000, 32'h0, 1);
        send_word(OP_INSERT, 16'h0000, 32'h0000_0000, 0);
        send_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_word(OP_INSERT, 16'h1234, 32'hA5A5_5A5A, 0);
        send_word(OP_INSERT, 16'h1234, 32'h5A5A_A5A5, 2);
        send_word(OP_LOOKUP, 16'h1234, 32'hFFFF_FFFF, 0);
        send_word(OP_LOOKUP, 16'h1235, 32'h0, 0);
        send_word(OP_FLOOR,  16'hFFFF, 32'h0, 0);
        for (int i = 0; i < 4; i++) send_word(OP_NEXT, 16'h0, 32'h0, 0);
        // Floor search that has to back out of the 0x123x node.
        send_word(OP_FLOOR,  16'h1233, 32'h0, 0);
        send_word(OP_INSERT, 16'h8000, 32'h1357_9BDF, 0);
        send_word(OP_FLOOR,  16'h7FFF, 32'h0, 0);
        send_word(OP_NEXT,   16'h0, 32'h0, 0);
        send_word(OP_REMOVE, 16'h1234, 32'h0, 0);
        send_word(OP_REMOVE, 16'h1234, 32'h0, 0);
        send_word(OP_LOOKUP, 16'h1234, 32'h0, 0);
        send_word(3'd5,      16'hFFFF, 32'hFFFF_FFFF, 0);
        send_word(3'd7,      16'h0000, 32'h0, 0);
        send_word(OP_FLOOR,  16'h1234, 32'h0, 0);
        send_word(OP_REMOVE, 16'hFFFF, 32'h0, 0);
        send_word(OP_REMOVE, 16'h0000, 32'h0, 3);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            for (int i = 0; i < 32; i++) key_set[i] = 16'($urandom);
            // Clustered keys in the first phase exercise shared interior nodes.
            if (phase == 0)
                for (int i = 0; i < 32; i++)
                    key_set[i] = {key_set[0][15:8], 8'($urandom)};
            case (phase)
                0: random_phase(350, 35, 15, 10);
                1: random_phase(300, 30, 20, 20);
                // Insert-heavy on spread keys until the pool refuses nodes.
                2: random_phase(380, 80, 5, 90);
                3: random_phase(300, 5, 60, 30);
            endcase
            wait_drained();
        end

        repeat (100) @(posedge aclk);
        $display("%0d words sent, %0d answered ok, %0d inserts refused for lack of nodes",
                 words_sent, hit_count, full_count);
        if (fail_count == 0 && pending == 0) begin
            $display("radix_trie_map regression: pass");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending);
            $display("radix_trie_map regression: fail");
        end
        $finish;
    end

endmodule
